>>> sv/matrix_slice_multiply_assert.svh
// Assertion shorthands for matrix_slice_multiply; they expect clk and arst_n in scope.
`ifndef MATRIX_SLICE_MULTIPLY_ASSERT_SVH
`define MATRIX_SLICE_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define MSM_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/msm_pkg.sv
`default_nettype none

package msm_pkg;

	localparam int CFG_W = 5;
	localparam int ROW_W = 4;
	localparam int COL_W = 4;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;
	localparam int CMD_W = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
	localparam logic [0:0] REG_SLICE_ROWS  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [ROW_W-1:0]        row_index;
		logic [COL_W-1:0]        col_index;
		logic signed [VAL_W-1:0] element_value;
	} msm_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_sum;
		logic                    status;
	} msm_result_t;

	typedef struct packed {
		logic [0:0]       index;
		logic [CFG_W-1:0] value;
	} msm_cfg_t;

	typedef enum logic [1:0] {
		OP_WRITE_A,
		OP_WRITE_B,
		OP_COMPUTE,
		OP_RANGE_ERR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} msm_entry_t;

	// clamped register values
	typedef struct packed {
		logic [CFG_W-1:0] n;
		logic [CFG_W-1:0] rows;
	} msm_dims_t;

	typedef struct packed {
		logic empty;
		logic full;
	} msm_q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_FINISH
	} bk_state_t;

	function automatic logic signed [SUM_W-1:0] sat_add64(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W-1:0] s;
		s = a + b;
		if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
			if (a[SUM_W-1])
				s = {1'b1, {(SUM_W-1){1'b0}}};
			else
				s = {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> sv/msm_chan_if.sv
`default_nettype none

interface msm_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/msm_ram.sv
`default_nettype none

module msm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/msm_front.sv
`default_nettype none

module msm_front #(
	parameter int MAX_DIM  = 16,
	parameter int MAX_ROWS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	msm_chan_if.sink                 item,
	msm_chan_if.sink                 cfg,
	input  wire msm_pkg::msm_q_status_t q_stat,
	output logic                     q_push,
	output msm_pkg::msm_entry_t      q_entry,
	output msm_pkg::msm_dims_t       dims
);
	import msm_pkg::*;

	logic [CFG_W-1:0] size_q;
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] n_eff;
	logic [CFG_W-1:0] rows_eff;
	logic             row_in_slice;
	logic             row_in_n;
	logic             col_in_n;
	logic             keep;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_W'(1);
			rows_q <= CFG_W'(1);
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_MATRIX_SIZE: size_q <= cfg.data.value;
				REG_SLICE_ROWS:  rows_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// zero reads as one, anything past the store bound reads as the bound
	always_comb begin
		if (size_q == '0)
			n_eff = CFG_W'(1);
		else if (int'(size_q) > MAX_DIM)
			n_eff = CFG_W'(MAX_DIM);
		else
			n_eff = size_q;

		if (rows_q == '0)
			rows_eff = CFG_W'(1);
		else if (int'(rows_q) > MAX_ROWS)
			rows_eff = CFG_W'(MAX_ROWS);
		else
			rows_eff = rows_q;
	end

	assign dims.n    = n_eff;
	assign dims.rows = rows_eff;

	assign row_in_slice = {1'b0, item.data.row_index} < rows_eff;
	assign row_in_n     = {1'b0, item.data.row_index} < n_eff;
	assign col_in_n     = {1'b0, item.data.col_index} < n_eff;

	always_comb begin
		q_entry.row   = item.data.row_index;
		q_entry.col   = item.data.col_index;
		q_entry.value = item.data.element_value;
		q_entry.op    = OP_RANGE_ERR;
		keep          = 1'b0;
		case (item.data.cmd)
			CMD_WRITE_A: begin
				q_entry.op = OP_WRITE_A;
				keep       = row_in_slice && col_in_n;
			end
			CMD_WRITE_B: begin
				q_entry.op = OP_WRITE_B;
				keep       = row_in_n && col_in_n;
			end
			CMD_COMPUTE: begin
				q_entry.op = (row_in_slice && col_in_n) ? OP_COMPUTE : OP_RANGE_ERR;
				keep       = 1'b1;
			end
			default: ;
		endcase
	end

	// dropped beats are still taken, they just never reach the queue
	assign item.ready = !q_stat.full;
	assign q_push     = item.valid && item.ready && keep;

endmodule

`default_nettype wire

>>> sv/msm_queue.sv
`default_nettype none

module msm_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire msm_pkg::msm_entry_t    entry_in,
	input  wire logic                   pop,
	output msm_pkg::msm_entry_t         entry_out,
	output msm_pkg::msm_q_status_t      stat
);
	import msm_pkg::*;

	msm_entry_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + QPTR_W'(1);
	endfunction

	assign entry_out  = entries_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= entry_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/msm_back.sv
`default_nettype none

module msm_back #(
	parameter int MAX_DIM  = 16,
	parameter int MAX_ROWS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire msm_pkg::msm_entry_t    q_entry,
	input  wire msm_pkg::msm_q_status_t q_stat,
	output logic                        q_pop,
	input  wire msm_pkg::msm_dims_t     dims,
	msm_chan_if.source                  result
);
	import msm_pkg::*;

	localparam int A_DEPTH = MAX_ROWS * MAX_DIM;
	localparam int B_DEPTH = MAX_DIM * MAX_DIM;
	localparam int A_AW    = $clog2(A_DEPTH);
	localparam int B_AW    = $clog2(B_DEPTH);

	bk_state_t state_q, state_d;

	logic [CFG_W-1:0]        k_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [SUM_W-1:0] acc_q;
	logic                    rd_vld_s1;
	logic                    prod_vld_s2;
	logic signed [SUM_W-1:0] prod_s2;
	logic                    res_vld_q;
	msm_result_t             res_q;

	logic [VAL_W-1:0]        a_rdata;
	logic [VAL_W-1:0]        b_rdata;
	logic signed [VAL_W-1:0] a_op;
	logic signed [VAL_W-1:0] b_op;
	logic [A_AW-1:0]         a_waddr, a_raddr;
	logic [B_AW-1:0]         b_waddr, b_raddr;

	logic wr_a, wr_b, rd_en, start, load_ok, load_err;
	logic out_free, pipe_empty, last_k;

	assign out_free   = !res_vld_q || result.ready;
	assign pipe_empty = !rd_vld_s1 && !prod_vld_s2;
	assign last_k     = (k_q == dims.n - CFG_W'(1));

	assign a_waddr = A_AW'(int'(q_entry.row) * MAX_DIM + int'(q_entry.col));
	assign b_waddr = B_AW'(int'(q_entry.row) * MAX_DIM + int'(q_entry.col));
	assign a_raddr = A_AW'(int'(row_q) * MAX_DIM + int'(k_q));
	assign b_raddr = B_AW'(int'(k_q) * MAX_DIM + int'(col_q));

	msm_ram #(.WIDTH(VAL_W), .DEPTH(A_DEPTH)) u_slice_ram (
		.clk   (clk),
		.we    (wr_a),
		.waddr (a_waddr),
		.wdata (q_entry.value),
		.re    (rd_en),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	msm_ram #(.WIDTH(VAL_W), .DEPTH(B_DEPTH)) u_square_ram (
		.clk   (clk),
		.we    (wr_b),
		.waddr (b_waddr),
		.wdata (q_entry.value),
		.re    (rd_en),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty && q_entry.op == OP_COMPUTE)
					state_d = BK_ISSUE;
			end
			BK_ISSUE: begin
				if (last_k)
					state_d = BK_FINISH;
			end
			BK_FINISH: begin
				if (pipe_empty && out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		wr_a     = 1'b0;
		wr_b     = 1'b0;
		rd_en    = 1'b0;
		start    = 1'b0;
		load_ok  = 1'b0;
		load_err = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					case (q_entry.op)
						OP_WRITE_A: begin
							q_pop = 1'b1;
							wr_a  = 1'b1;
						end
						OP_WRITE_B: begin
							q_pop = 1'b1;
							wr_b  = 1'b1;
						end
						OP_COMPUTE: begin
							q_pop = 1'b1;
							start = 1'b1;
						end
						OP_RANGE_ERR: begin
							q_pop    = out_free;
							load_err = out_free;
						end
						default: ;
					endcase
				end
			end
			BK_ISSUE:  rd_en   = 1'b1;
			BK_FINISH: load_ok = pipe_empty && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_vld_s1   <= rd_en;
			prod_vld_s2 <= rd_vld_s1;
			if (load_ok || load_err)
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
		end
	end

	assign a_op = a_rdata;
	assign b_op = b_rdata;

	// one MAC lane: read, multiply, saturating add
	always_ff @(posedge clk) begin
		if (start) begin
			k_q   <= '0;
			row_q <= q_entry.row;
			col_q <= q_entry.col;
		end else if (rd_en) begin
			k_q <= k_q + CFG_W'(1);
		end

		prod_s2 <= a_op * b_op;

		if (start)
			acc_q <= '0;
		else if (prod_vld_s2)
			acc_q <= sat_add64(acc_q, prod_s2);

		if (load_err) begin
			res_q.product_sum <= '0;
			res_q.status      <= STATUS_RANGE;
		end else if (load_ok) begin
			res_q.product_sum <= acc_q;
			res_q.status      <= STATUS_OK;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

>>> sv/matrix_slice_multiply.sv
// matrix_slice_multiply: load beats (cmd 0/1) write one Q16.16 element of the A slice or of
// square B into on-chip RAM; a compute beat (cmd 2) returns the Q32.32 dot product of A row
// row_index with B column col_index, summed over k < n with saturation at 64 bits, where n is
// matrix_size with zero read as one and anything above MAX_DIM read as MAX_DIM.
// Out-of-range loads and cmd 3 are taken and dropped; an out-of-range compute returns zero with
// status 1. Accepted beats pass through a two-entry queue to the execution side, so the input
// keeps flowing while a result waits on the output register, until the queue is full. A load
// leaves the queue without waiting on the output; a compute runs the single multiply-accumulate
// lane, which reads one A/B pair per cycle, followed by the RAM read, multiply and accumulate
// registers. A range error or a compute waits for the output register before posting a result.
// Registers may only be written while the block is idle. Elements must be loaded before a
// compute reads them.
`default_nettype none

`include "matrix_slice_multiply_assert.svh"

module matrix_slice_multiply #(
	parameter int MAX_DIM  = 16,
	parameter int MAX_ROWS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msm_chan_if.sink   item,
	msm_chan_if.sink   cfg,
	msm_chan_if.source result
);
	import msm_pkg::*;

	logic          q_push;
	logic          q_pop;
	msm_entry_t    q_entry_in;
	msm_entry_t    q_entry_out;
	msm_q_status_t q_stat;
	msm_dims_t     dims;
	logic          err_beat;
	logic          compute_pop;

	msm_front #(.MAX_DIM(MAX_DIM), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_entry (q_entry_in),
		.dims    (dims)
	);

	msm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (q_entry_in),
		.pop       (q_pop),
		.entry_out (q_entry_out),
		.stat      (q_stat)
	);

	msm_back #(.MAX_DIM(MAX_DIM), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (q_entry_out),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.dims    (dims),
		.result  (result)
	);

	assign err_beat    = result.valid && (result.data.status == STATUS_RANGE);
	assign compute_pop = q_pop && (q_entry_out.op == OP_COMPUTE);

	`MSM_ASSERT_IMPLIES(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty queue")
	`MSM_ASSERT_IMPLIES(a_full_stalls, q_stat.full, !item.ready, "input taken into full queue")
	`MSM_ASSERT_IMPLIES(a_err_zero, err_beat, result.data.product_sum == '0, "range error, nonzero sum")
	`MSM_ASSERT_NEXT(a_compute_busy, compute_pop, !q_pop, "queue popped during compute")

endmodule

`default_nettype wire

>>> dv/tb_matrix_slice_multiply.sv
module tb_matrix_slice_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	import msm_pkg::*;

	localparam int DIM_MAX  = 16;
	localparam int ROWS_MAX = 16;
	// two queued computes of the largest size plus margin
	localparam int SETTLE_CYCLES = 2 * (DIM_MAX + 4) + 8;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n;

	msm_chan_if #(.payload_t(msm_item_t))   item_ch ();
	msm_chan_if #(.payload_t(msm_cfg_t))    cfg_ch ();
	msm_chan_if #(.payload_t(msm_result_t)) result_ch ();

	matrix_slice_multiply #(
		.MAX_DIM (DIM_MAX),
		.MAX_ROWS(ROWS_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch.sink),
		.cfg   (cfg_ch.sink),
		.result(result_ch.source)
	);

	always #5ns clk = ~clk;

	// shadow of the block's registers and stores
	logic [CFG_W-1:0]        size_reg;
	logic [CFG_W-1:0]        rows_reg;
	logic signed [VAL_W-1:0] a_elems [ROWS_MAX][DIM_MAX];
	logic signed [VAL_W-1:0] b_elems [DIM_MAX][DIM_MAX];
	bit                      a_loaded [ROWS_MAX][DIM_MAX];
	bit                      b_loaded [DIM_MAX][DIM_MAX];

	msm_result_t expected_products [$];

	int  errors;
	int  useful_items;
	int  burst_left;
	bit  gaps_enabled;
	int  stall_mode;
	int  mode_left;
	int  beat_phase;
	logic holding;
	event hold_off_ev;

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	function automatic int cur_n();
		return clamp_dim(size_reg, DIM_MAX);
	endfunction

	function automatic int cur_rows();
		return clamp_dim(rows_reg, ROWS_MAX);
	endfunction

	// Q16.16 x Q16.16 products summed in Q32.32, clipped after every add
	function automatic msm_result_t dot_product(input int r, input int c);
		msm_result_t res;
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] prod;
		logic signed [SUM_W:0]   wide;
		acc = '0;
		for (int k = 0; k < cur_n(); k++) begin
			prod = a_elems[r][k] * b_elems[k][c];
			wide = acc + prod;
			if (wide > SUM_MAX)
				acc = SUM_MAX;
			else if (wide < SUM_MIN)
				acc = SUM_MIN;
			else
				acc = wide[SUM_W-1:0];
		end
		res.product_sum = acc;
		res.status = STATUS_OK;
		return res;
	endfunction

	// updates the shadow for one accepted beat; returns 1 if the beat did anything
	function automatic bit apply_item(input msm_item_t it);
		msm_result_t res;
		int r;
		int c;
		r = it.row_index;
		c = it.col_index;
		case (it.cmd)
			CMD_WRITE_A: begin
				if (r < cur_rows() && c < cur_n()) begin
					a_elems[r][c] = it.element_value;
					a_loaded[r][c] = 1'b1;
					return 1'b1;
				end
			end
			CMD_WRITE_B: begin
				if (r < cur_n() && c < cur_n()) begin
					b_elems[r][c] = it.element_value;
					b_loaded[r][c] = 1'b1;
					return 1'b1;
				end
			end
			CMD_COMPUTE: begin
				if (r >= cur_rows() || c >= cur_n()) begin
					res.product_sum = '0;
					res.status = STATUS_RANGE;
				end else begin
					res = dot_product(r, c);
				end
				expected_products.push_back(res);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic msm_item_t make_item(input logic [CMD_W-1:0] cmd, input int r,
			input int c, input logic [VAL_W-1:0] v);
		msm_item_t it;
		it.cmd = cmd;
		it.row_index = ROW_W'(r);
		it.col_index = COL_W'(c);
		it.element_value = v;
		return it;
	endfunction

	function automatic logic [VAL_W-1:0] rand_element();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return $urandom_range(0, 32'h0003_FFFF);
			4: return -$urandom_range(0, 32'h0003_FFFF);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input msm_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = 0;
			if (gaps_enabled && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		if (apply_item(it))
			useful_items++;
	endtask

	// loads whatever the dot product still needs, then asks for it
	task automatic compute_cell(input int r, input int c);
		if (r < cur_rows() && c < cur_n()) begin
			for (int k = 0; k < cur_n(); k++) begin
				if (!a_loaded[r][k])
					send_item(make_item(CMD_WRITE_A, r, k, rand_element()));
				if (!b_loaded[k][c])
					send_item(make_item(CMD_WRITE_B, k, c, rand_element()));
			end
		end
		send_item(make_item(CMD_COMPUTE, r, c, $urandom()));
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_products.size() != 0)
			@(posedge clk);
		// loads give no result, so let the last ones retire
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, value: v};
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MATRIX_SIZE)
			size_reg = v;
		else
			rows_reg = v;
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] n_val, input logic [CFG_W-1:0] rows_val);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_MATRIX_SIZE, n_val);
			write_reg(REG_SLICE_ROWS, rows_val);
		end else begin
			write_reg(REG_SLICE_ROWS, rows_val);
			write_reg(REG_MATRIX_SIZE, n_val);
		end
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int stop;
		int pick;
		stop = useful_items + count;
		while (useful_items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				compute_cell($urandom_range(0, cur_rows() - 1), $urandom_range(0, cur_n() - 1));
			else if (pick < 62)
				send_item(make_item(CMD_WRITE_A, $urandom_range(0, cur_rows() - 1),
					$urandom_range(0, cur_n() - 1), rand_element()));
			else if (pick < 74)
				send_item(make_item(CMD_WRITE_B, $urandom_range(0, cur_n() - 1),
					$urandom_range(0, cur_n() - 1), rand_element()));
			else if (pick < 84)
				compute_cell($urandom_range(0, 15), $urandom_range(0, 15));
			else if (pick < 89)
				send_item(make_item(CMD_WRITE_A, $urandom_range(0, 15), $urandom_range(0, 15),
					rand_element()));
			else if (pick < 94)
				send_item(make_item(CMD_WRITE_B, $urandom_range(0, 15), $urandom_range(0, 15),
					rand_element()));
			else
				send_item(make_item(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom()));
		end
	endtask

	// 1x1 after reset: one product, dropped loads, range errors, unused command
	task automatic test_reset_sizes();
		send_item(make_item(CMD_WRITE_A, 0, 0, Q_MAX));
		send_item(make_item(CMD_WRITE_B, 0, 0, Q_MAX));
		compute_cell(0, 0);
		send_item(make_item(CMD_WRITE_A, 0, 1, Q_MIN));
		send_item(make_item(CMD_WRITE_B, 1, 0, Q_MIN));
		send_item(make_item(CMD_WRITE_A, 15, 15, '1));
		compute_cell(1, 0);
		compute_cell(0, 1);
		compute_cell(15, 15);
		send_item(make_item(CMD_UNUSED, 15, 15, '1));
	endtask

	// clipping at both limits, and a sum pulled back after it clipped
	task automatic test_saturation();
		set_dims(5'd3, 5'd2);
		for (int k = 0; k < 3; k++) begin
			send_item(make_item(CMD_WRITE_A, 0, k, Q_MIN));
			send_item(make_item(CMD_WRITE_A, 1, k, (k == 2) ? Q_MAX : Q_MIN));
			send_item(make_item(CMD_WRITE_B, k, 0, Q_MIN));
			send_item(make_item(CMD_WRITE_B, k, 1, Q_MAX));
		end
		compute_cell(0, 0);
		compute_cell(0, 1);
		compute_cell(1, 0);
		compute_cell(1, 1);
		compute_cell(2, 0);
		compute_cell(0, 3);
	endtask

	// zero reads as one, anything past the maximum as the maximum
	task automatic test_register_extremes();
		set_dims(5'd0, 5'd0);
		random_traffic(30);
		set_dims(5'd31, 5'd31);
		random_traffic(50);
		set_dims(5'd16, 5'd16);
		random_traffic(30);
		set_dims(5'd2, 5'd17);
		random_traffic(25);
	endtask

	task automatic test_random_sizes();
		for (int p = 0; p < 6; p++) begin
			set_dims(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 8)));
			random_traffic(55);
		end
	endtask

	// output held off while the sender keeps pushing: the block has to stall its input
	task automatic test_backpressure();
		set_dims(5'd3, 5'd4);
		gaps_enabled = 1'b0;
		-> hold_off_ev;
		random_traffic(40);
		gaps_enabled = 1'b1;
	endtask

	initial begin
		forever begin
			@(hold_off_ev);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	// result side: check each beat, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				check_result(result_ch.data);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			beat_phase = (beat_phase + 1) % 3;
			case (stall_mode)
				0: result_ch.ready <= !holding;
				1: result_ch.ready <= !holding && $urandom_range(0, 1);
				2: result_ch.ready <= !holding && (beat_phase == 0);
				default: result_ch.ready <= !holding && ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	task automatic check_result(input msm_result_t got);
		msm_result_t want;
		if (expected_products.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: expected none, actual sum %h status %0d",
				$time, got.product_sum, got.status);
		end else begin
			want = expected_products.pop_front();
			if (got.product_sum !== want.product_sum) begin
				errors++;
				$display("%0t: product_sum mismatch: expected %h actual %h",
					$time, want.product_sum, got.product_sum);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d",
					$time, want.status, got.status);
			end
		end
	endtask

	initial begin
		#2ms;
		$display("tb_matrix_slice_multiply NOT OK");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		holding = 1'b0;
		size_reg = 5'd1;
		rows_reg = 5'd1;
		errors = 0;
		useful_items = 0;
		burst_left = 0;
		gaps_enabled = 1'b1;
		stall_mode = 0;
		mode_left = 0;
		beat_phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_saturation();
		test_register_extremes();
		test_random_sizes();
		test_backpressure();

		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_matrix_slice_multiply OK");
		else
			$display("tb_matrix_slice_multiply NOT OK");
		$finish;
	end

endmodule
